### rtl/core/scancode_to_ascii_decoder_top_defines.svh
// assertion macros for the scancode decoder
// expects clk and rst_n in the scope of use, no other dependencies
`ifndef SCANCODE_TO_ASCII_DECODER_TOP_DEFINES_SVH
`define SCANCODE_TO_ASCII_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define S2A_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define S2A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/s2a_pkg.sv
// types, codes and translation tables for the scancode decoder
// no dependencies
`default_nettype none

package s2a_pkg;

  localparam int unsigned CODE_W = 8;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned SKIP_W = 2;

  localparam logic [CODE_W-1:0] CODE_EXT0   = 8'hE0;
  localparam logic [CODE_W-1:0] CODE_EXT1   = 8'hE1;
  localparam logic [CHAR_W-1:0] KEY_LSHIFT  = 7'h2A;
  localparam logic [CHAR_W-1:0] KEY_RSHIFT  = 7'h36;
  localparam logic [CHAR_W-1:0] KEY_LCTRL   = 7'h1D;
  localparam logic [CHAR_W-1:0] KEY_LALT    = 7'h38;
  localparam logic [SKIP_W-1:0] SKIP_EXT0   = 2'd1;
  localparam logic [SKIP_W-1:0] SKIP_EXT1   = 2'd2;

  typedef struct packed {
    logic alt;
    logic ctrl;
    logic shift;
  } s2a_mods_t;

  typedef struct packed {
    s2a_mods_t         mods;
    logic [SKIP_W-1:0] skip;
  } s2a_state_t;

  typedef struct packed {
    s2a_state_t        state;
    logic              emit;
    logic [CHAR_W-1:0] ch;
  } s2a_result_t;

  // which modifier a key code stands for
  function automatic s2a_mods_t modifier_of(input logic [CHAR_W-1:0] key);
    s2a_mods_t m;
    m = '0;
    m.shift = (key == KEY_LSHIFT) || (key == KEY_RSHIFT);
    m.ctrl  = (key == KEY_LCTRL);
    m.alt   = (key == KEY_LALT);
    return m;
  endfunction

  // unshifted layout
  function automatic logic [CHAR_W-1:0] plain_char(input logic [CHAR_W-1:0] key);
    logic [CHAR_W-1:0] c;
    unique case (key)
      7'h01: c = 7'h1B; 7'h02: c = 7'h31; 7'h03: c = 7'h32; 7'h04: c = 7'h33;
      7'h05: c = 7'h34; 7'h06: c = 7'h35; 7'h07: c = 7'h36; 7'h08: c = 7'h37;
      7'h09: c = 7'h38; 7'h0A: c = 7'h39; 7'h0B: c = 7'h30; 7'h0C: c = 7'h2D;
      7'h0D: c = 7'h3D; 7'h0E: c = 7'h08; 7'h0F: c = 7'h09;
      7'h10: c = 7'h71; 7'h11: c = 7'h77; 7'h12: c = 7'h65; 7'h13: c = 7'h72;
      7'h14: c = 7'h74; 7'h15: c = 7'h79; 7'h16: c = 7'h75; 7'h17: c = 7'h69;
      7'h18: c = 7'h6F; 7'h19: c = 7'h70; 7'h1A: c = 7'h5B; 7'h1B: c = 7'h5D;
      7'h1C: c = 7'h0D; 7'h1E: c = 7'h61; 7'h1F: c = 7'h73;
      7'h20: c = 7'h64; 7'h21: c = 7'h66; 7'h22: c = 7'h67; 7'h23: c = 7'h68;
      7'h24: c = 7'h6A; 7'h25: c = 7'h6B; 7'h26: c = 7'h6C; 7'h27: c = 7'h3B;
      7'h28: c = 7'h27; 7'h29: c = 7'h60; 7'h2B: c = 7'h5C;
      7'h2C: c = 7'h7A; 7'h2D: c = 7'h78; 7'h2E: c = 7'h63; 7'h2F: c = 7'h76;
      7'h30: c = 7'h62; 7'h31: c = 7'h6E; 7'h32: c = 7'h6D; 7'h33: c = 7'h2C;
      7'h34: c = 7'h2E; 7'h35: c = 7'h2F; 7'h37: c = 7'h2A; 7'h39: c = 7'h20;
      7'h47: c = 7'h37; 7'h48: c = 7'h38; 7'h49: c = 7'h39; 7'h4A: c = 7'h2D;
      7'h4B: c = 7'h34; 7'h4C: c = 7'h35; 7'h4D: c = 7'h36; 7'h4E: c = 7'h2B;
      7'h4F: c = 7'h31; 7'h50: c = 7'h32; 7'h51: c = 7'h33; 7'h52: c = 7'h30;
      7'h53: c = 7'h2E;
      default: c = '0;
    endcase
    return c;
  endfunction

  // shifted layout
  function automatic logic [CHAR_W-1:0] upper_char(input logic [CHAR_W-1:0] key);
    logic [CHAR_W-1:0] c;
    unique case (key)
      7'h01: c = 7'h1B; 7'h02: c = 7'h21; 7'h03: c = 7'h40; 7'h04: c = 7'h23;
      7'h05: c = 7'h24; 7'h06: c = 7'h25; 7'h07: c = 7'h5E; 7'h08: c = 7'h26;
      7'h09: c = 7'h2A; 7'h0A: c = 7'h28; 7'h0B: c = 7'h29; 7'h0C: c = 7'h5F;
      7'h0D: c = 7'h2B; 7'h0E: c = 7'h08; 7'h0F: c = 7'h09;
      7'h10: c = 7'h51; 7'h11: c = 7'h57; 7'h12: c = 7'h45; 7'h13: c = 7'h52;
      7'h14: c = 7'h54; 7'h15: c = 7'h59; 7'h16: c = 7'h55; 7'h17: c = 7'h49;
      7'h18: c = 7'h4F; 7'h19: c = 7'h50; 7'h1A: c = 7'h7B; 7'h1B: c = 7'h7D;
      7'h1C: c = 7'h0D; 7'h1E: c = 7'h41; 7'h1F: c = 7'h53;
      7'h20: c = 7'h44; 7'h21: c = 7'h46; 7'h22: c = 7'h47; 7'h23: c = 7'h48;
      7'h24: c = 7'h4A; 7'h25: c = 7'h4B; 7'h26: c = 7'h4C; 7'h27: c = 7'h3A;
      7'h28: c = 7'h22; 7'h29: c = 7'h7E; 7'h2B: c = 7'h7C;
      7'h2C: c = 7'h5A; 7'h2D: c = 7'h58; 7'h2E: c = 7'h43; 7'h2F: c = 7'h56;
      7'h30: c = 7'h42; 7'h31: c = 7'h4E; 7'h32: c = 7'h4D; 7'h33: c = 7'h3C;
      7'h34: c = 7'h3E; 7'h35: c = 7'h3F; 7'h37: c = 7'h2A; 7'h39: c = 7'h20;
      7'h47: c = 7'h37; 7'h48: c = 7'h38; 7'h49: c = 7'h39; 7'h4A: c = 7'h2D;
      7'h4B: c = 7'h34; 7'h4C: c = 7'h35; 7'h4D: c = 7'h36; 7'h4E: c = 7'h2B;
      7'h4F: c = 7'h31; 7'h50: c = 7'h32; 7'h51: c = 7'h33; 7'h52: c = 7'h30;
      7'h53: c = 7'h2E;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/s2a_if.sv
// valid/ready channel interfaces for scancode bytes and characters
// depends on s2a_pkg for field widths
`default_nettype none

interface s2a_code_if;
  logic                          valid;
  logic                          ready;
  logic [s2a_pkg::CODE_W-1:0]    scancode;

  modport source (output valid, output scancode, input ready);
  modport sink   (input valid, input scancode, output ready);
endinterface

interface s2a_char_if;
  logic                          valid;
  logic                          ready;
  logic [s2a_pkg::CHAR_W-1:0]    ascii_char;

  modport source (output valid, output ascii_char, input ready);
  modport sink   (input valid, input ascii_char, output ready);
endinterface

`default_nettype wire

### rtl/core/s2a_decode.sv
// per-word decode: prefix skip, release handling, table lookup, modifier update
// depends on s2a_pkg
`default_nettype none

module s2a_decode (
  input  wire logic [s2a_pkg::CODE_W-1:0] code,
  input  wire s2a_pkg::s2a_state_t        cur_state,
  output s2a_pkg::s2a_result_t            res
);

  logic [s2a_pkg::CHAR_W-1:0] key;
  logic [s2a_pkg::CHAR_W-1:0] lookup;
  s2a_pkg::s2a_mods_t         key_mod;

  assign key     = code[s2a_pkg::CHAR_W-1:0];
  assign key_mod = s2a_pkg::modifier_of(key);

  // shift wins over alt, alt blanks the press
  always_comb begin
    if (cur_state.mods.shift) begin
      lookup = s2a_pkg::upper_char(key);
    end else if (cur_state.mods.alt) begin
      lookup = '0;
    end else begin
      lookup = s2a_pkg::plain_char(key);
    end
  end

  always_comb begin
    res       = '0;
    res.state = cur_state;
    if (cur_state.skip != '0) begin
      res.state.skip = cur_state.skip - 2'd1;
    end else if (code == s2a_pkg::CODE_EXT0) begin
      res.state.skip = s2a_pkg::SKIP_EXT0;
    end else if (code == s2a_pkg::CODE_EXT1) begin
      res.state.skip = s2a_pkg::SKIP_EXT1;
    end else if (code[s2a_pkg::CODE_W-1]) begin
      res.state.mods = cur_state.mods & ~key_mod;
    end else if (lookup != '0) begin
      res.emit = 1'b1;
      res.ch   = lookup;
    end else begin
      res.state.mods = cur_state.mods | key_mod;
    end
  end

endmodule

`default_nettype wire

### rtl/core/scancode_to_ascii_decoder_top.sv
// top level of the scancode set 1 to ascii decoder
// depends on s2a_pkg, s2a_if, s2a_decode and the assertion macro header
//
//   channel   | dir | payload              | handshake
//   ----------+-----+----------------------+------------
//   in_code   | in  | scancode [7:0]       | valid/ready
//   out_char  | out | ascii_char [6:0]     | valid/ready
//
// one word per cycle sustained while out_char is not stalled; an accepted
// scancode word passes the input register, then the result register, to out_char
// prefix, release and modifier words give no character and only move state
// rst_n is synchronous: clears valids, modifier flags and skip count
// a stalled out_char holds its word; the input register keeps moving while
// the result register is free or being emptied in the same cycle
`default_nettype none
`include "scancode_to_ascii_decoder_top_defines.svh"

module scancode_to_ascii_decoder_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  s2a_code_if.sink    in_code,
  s2a_char_if.source  out_char
);

  // input register
  logic                        s1_valid_r, s1_valid_nxt;
  logic [s2a_pkg::CODE_W-1:0]  s1_code_r;

  // decoder state
  s2a_pkg::s2a_state_t         state_r;
  s2a_pkg::s2a_result_t        dec;

  // result register
  logic                        out_valid_r, out_valid_nxt;
  logic [s2a_pkg::CHAR_W-1:0]  out_char_r;

  logic in_acc;
  logic out_free;
  logic s1_adv;
  logic out_load;

  s2a_decode u_decode (
    .code      (s1_code_r),
    .cur_state (state_r),
    .res       (dec)
  );

  // result slot is free when empty or being taken this cycle
  assign out_free = !out_valid_r || out_char.ready;
  // staged word moves on whenever a result could be stored
  assign s1_adv   = s1_valid_r && out_free;
  assign out_load = s1_adv && dec.emit;

  assign in_code.ready = !s1_valid_r || s1_adv;
  assign in_acc        = in_code.valid && in_code.ready;

  assign out_char.valid      = out_valid_r;
  assign out_char.ascii_char = out_char_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_char.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        state_r <= dec.state;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_code_r <= in_code.scancode;
    end
    if (out_load) begin
      out_char_r <= dec.ch;
    end
  end

  // a skipped word never produces a character
  `S2A_ASSERT_NOW(a_skip_no_emit, s1_adv && (state_r.skip != 2'd0), !out_load,
                  "skipped word emitted")

  // an emitted character is never zero
  `S2A_ASSERT_NOW(a_emit_nonzero, out_load, dec.ch != '0, "zero character emitted")

  // a staged word that cannot move is kept
  `S2A_ASSERT_NEXT(a_stage_hold, s1_valid_r && !s1_adv,
                   s1_valid_r && $stable(s1_code_r), "staged word lost")

  // releasing left shift outside a prefix clears the shift flag
  `S2A_ASSERT_NEXT(a_shift_release,
                   s1_adv && (state_r.skip == 2'd0) &&
                   (s1_code_r == {1'b1, s2a_pkg::KEY_LSHIFT}),
                   !state_r.mods.shift, "shift not released")

endmodule

`default_nettype wire
